/* hw/rtl/bsc_pkg.sv */
// shared types, constants and symbol lookup for the byte to code word packer
package bsc_pkg;

    localparam int unsigned SYM_W   = 6;
    localparam int unsigned WORD_W  = 12;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [WORD_W-1:0] RAW_PREFIX = 12'hF00;
    localparam logic [SYM_W-1:0]  NO_SYMBOL  = 6'd0;

    // register indexes
    localparam logic REG_RAW_ONLY = 1'b0;

    // word count per item
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // one result word with its flags
    typedef struct packed {
        logic [WORD_W-1:0] code_word;
        logic              last_of_run;
        logic              message_done;
    } code_item_t;

    // everything the encoder decides for one request
    typedef struct packed {
        logic [1:0]       word_count;
        code_item_t       word0;
        code_item_t       word1;
        logic             held_valid;
        logic [SYM_W-1:0] held_symbol;
    } enc_result_t;

    // free space seen by the encoder this cycle
    typedef struct packed {
        logic room_one;
        logic room_two;
    } fifo_room_t;

    // symbol code of an already folded byte, NO_SYMBOL if it is not in the table
    function automatic logic [SYM_W-1:0] symbol_code(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] diff;
        logic [SYM_W-1:0]  code;
        diff = '0;
        code = NO_SYMBOL;
        case (b) inside
            8'h08: code = 6'd1;
            8'h0D: code = 6'd2;
            8'h20: code = 6'd3;
            8'h21: code = 6'd4;
            8'h22: code = 6'd5;
            8'h27: code = 6'd6;
            // contiguous run from open paren to semicolon
            [8'h28:8'h3B]: begin
                diff = b - 8'h21;
                code = diff[SYM_W-1:0];
            end
            8'h3D: code = 6'd27;
            // contiguous run from question mark to upper-case z
            [8'h3F:8'h5A]: begin
                diff = b - 8'h23;
                code = diff[SYM_W-1:0];
            end
            8'h5C: code = 6'd56;
            8'h5E: code = 6'd57;
            8'h60: code = 6'd58;
            8'h7E: code = 6'd59;
            default: code = NO_SYMBOL;
        endcase
        return code;
    endfunction

endpackage

/* hw/rtl/bsc_encode.sv */
// folds one byte, looks up its symbol and builds up to two code words
module bsc_encode
    import bsc_pkg::*;
(
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              end_of_message,
    input  logic              raw_only,
    input  logic              held_valid,
    input  logic [SYM_W-1:0]  held_symbol,
    output enc_result_t       result
);

    logic [BYTE_W-1:0] folded;
    logic [SYM_W-1:0]  code;
    logic [WORD_W-1:0] raw_word;

    // lower-case to upper-case, newline to carriage return
    always_comb begin
        folded = byte_value;
        if (byte_value >= 8'h61 && byte_value <= 8'h7A) begin
            folded = byte_value - 8'h20;
        end
        if (byte_value == 8'h0A) begin
            folded = 8'h0D;
        end
    end

    assign code     = raw_only ? NO_SYMBOL : symbol_code(folded);
    assign raw_word = RAW_PREFIX | {{(WORD_W-BYTE_W){1'b0}}, byte_value};

    // word selection and held symbol update
    always_comb begin
        result             = '0;
        result.held_valid  = 1'b0;
        result.held_symbol = '0;
        if (code == NO_SYMBOL) begin
            if (held_valid) begin
                result.word_count              = CNT_TWO;
                result.word0.code_word         = {{(WORD_W-SYM_W){1'b0}}, held_symbol};
                result.word1.code_word         = raw_word;
                result.word1.last_of_run       = 1'b1;
                result.word1.message_done      = end_of_message;
            end else begin
                result.word_count              = CNT_ONE;
                result.word0.code_word         = raw_word;
                result.word0.last_of_run       = 1'b1;
                result.word0.message_done      = end_of_message;
            end
        end else if (held_valid) begin
            result.word_count              = CNT_ONE;
            result.word0.code_word         = {code, held_symbol};
            result.word0.last_of_run       = 1'b1;
            result.word0.message_done      = end_of_message;
        end else if (end_of_message) begin
            result.word_count              = CNT_ONE;
            result.word0.code_word         = {{(WORD_W-SYM_W){1'b0}}, code};
            result.word0.last_of_run       = 1'b1;
            result.word0.message_done      = 1'b1;
        end else begin
            result.word_count  = CNT_NONE;
            result.held_valid  = 1'b1;
            result.held_symbol = code;
        end
    end

endmodule

/* hw/rtl/bsc_out_fifo.sv */
// two-entry output queue that takes up to two words per cycle and gives one
module bsc_out_fifo
    import bsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  code_item_t push_word0,
    input  code_item_t push_word1,
    output fifo_room_t room,
    output logic       out_valid,
    input  logic       out_ready,
    output code_item_t out_word
);

    code_item_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_word  = entries_reg[rd_ptr_reg];

    // space left once this cycle's pop is counted
    assign room.room_one = (count_reg != 2'd2) || pop;
    assign room.room_two = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop);

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push_count[0];
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + push_count - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, second word goes into the slot after the first
    always_ff @(posedge aclk) begin
        if (push_count != CNT_NONE) begin
            entries_reg[wr_ptr_reg] <= push_word0;
        end
        if (push_count == CNT_TWO) begin
            entries_reg[~wr_ptr_reg] <= push_word1;
        end
    end

endmodule

/* hw/rtl/bytes_to_symbol_code_words.sv */
// top level of the byte to symbol code word packer
// Takes one message byte per request and gives 12-bit code words: two table
// symbols share a word (second in bits 11:6), a lone symbol goes out when a
// non-symbol follows or the message ends, and a non-symbol goes out as
// 0xF00 | byte. One request is taken per cycle while the output queue has
// room for its words; a request that gives two words takes the output side
// for both of them, since the two-entry output queue hands out one word per
// cycle. A request passes the input register and then the output queue. Register raw_only (byte
// address 0, bit 0) sends every byte as a raw word; write it only while idle.
module bytes_to_symbol_code_words
    import bsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // end_of_message
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] code_word, [15:12] zero
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser,   // [0] message_done
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              raw_only_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eom_reg;
    logic              held_valid_reg;
    logic              held_valid_next;
    logic [SYM_W-1:0]  held_symbol_reg;
    logic [SYM_W-1:0]  held_symbol_next;
    enc_result_t       enc;
    fifo_room_t        room;
    logic              consume;
    logic              s_accept;
    logic [1:0]        push_count;
    code_item_t        out_word;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RAW_ONLY) ? {31'd0, raw_only_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_only_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RAW_ONLY)) begin
            raw_only_reg <= pwdata[0];
        end
    end

    // encoder on the input register
    bsc_encode u_encode (
        .byte_value     (in_byte_reg),
        .end_of_message (in_eom_reg),
        .raw_only       (raw_only_reg),
        .held_valid     (held_valid_reg),
        .held_symbol    (held_symbol_reg),
        .result         (enc)
    );

    // request leaves the input register when the queue has room for its words
    always_comb begin
        consume = 1'b0;
        if (in_valid_reg) begin
            case (enc.word_count)
                CNT_NONE: consume = 1'b1;
                CNT_ONE:  consume = room.room_one;
                CNT_TWO:  consume = room.room_two;
                default:  consume = 1'b0;
            endcase
        end
    end

    assign push_count = consume ? enc.word_count : CNT_NONE;
    assign s_tready   = !in_valid_reg || consume;
    assign s_accept   = s_tvalid && s_tready;

    // input register and held symbol next values
    always_comb begin
        in_valid_next    = s_accept || (in_valid_reg && !consume);
        held_valid_next  = held_valid_reg;
        held_symbol_next = held_symbol_reg;
        if (consume) begin
            held_valid_next  = enc.held_valid;
            held_symbol_next = enc.held_symbol;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_symbol_reg <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            held_valid_reg  <= held_valid_next;
            held_symbol_reg <= held_symbol_next;
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_eom_reg  <= s_tlast;
        end
    end

    // output queue
    bsc_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_word0 (enc.word0),
        .push_word1 (enc.word1),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (out_word)
    );

    assign m_tdata = {{(16-WORD_W){1'b0}}, out_word.code_word};
    assign m_tlast = out_word.last_of_run;
    assign m_tuser = out_word.message_done;

`ifndef ASSERT_OFF
    // a two-word request only leaves when both words fit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && enc.word_count == CNT_TWO) |-> room.room_two)
        else $error("two words pushed without room");

    // nothing stays held after the end of a message
    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_eom_reg) |=> !held_valid_reg)
        else $error("symbol held past end of message");

    // message end only on the final word of a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("message done without last of run");
`endif

endmodule
